// ===== rtl/tssr_pkg.sv =====
// tile and sprite scanline renderer: shared constants, codes and types
// no dependencies; imported by every block module except tssr_ram
package tssr_pkg;

  localparam int SCREEN_COLUMNS_DEF = 160;
  localparam int SCREEN_ROWS_DEF    = 144;
  localparam int OBJECT_COUNT_DEF   = 40;

  localparam int VIDEO_BYTES   = 8192;
  localparam int VRAM_AW       = 13;
  localparam int TABLE_BYTES   = 160;
  localparam int OAM_AW        = 8;
  localparam int TABLE_OBJECTS = 40;

  // request opcodes
  localparam logic [1:0] OP_VRAM = 2'd0;
  localparam logic [1:0] OP_OAM  = 2'd1;
  localparam logic [1:0] OP_DRAW = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_LCDC = 3'd0;
  localparam logic [2:0] CFG_SCRL = 3'd1;
  localparam logic [2:0] CFG_WIN  = 3'd2;
  localparam logic [2:0] CFG_BGP  = 3'd3;
  localparam logic [2:0] CFG_OBP  = 3'd4;
  localparam logic [2:0] CFG_LYC  = 3'd5;
  localparam logic [2:0] CFG_STEN = 3'd6;

  // video memory offsets
  localparam logic [12:0] MAP0_BASE   = 13'h1800;
  localparam logic [12:0] MAP1_BASE   = 13'h1C00;
  localparam logic [12:0] SIGNED_BASE = 13'h1000;

  // lcd control bits
  localparam int LCDC_BG_EN   = 0;
  localparam int LCDC_OBJ_EN  = 1;
  localparam int LCDC_OBJ_16  = 2;
  localparam int LCDC_BG_MAP  = 3;
  localparam int LCDC_UNSIGN  = 4;
  localparam int LCDC_WIN_EN  = 5;
  localparam int LCDC_WIN_MAP = 6;

  typedef struct packed {
    logic       accept;
    logic       decode;
    logic       loop_clr;
    logic       clr;
    logic       cap_shade;
    logic       bg_map;
    logic       bg_lo;
    logic       bg_hi;
    logic       bg_wr;
    logic [1:0] oam_k;
    logic       cap_y;
    logic       cap_x;
    logic       cap_t;
    logic       cap_f;
    logic       obj_next;
    logic       obj_lo;
    logic       obj_hi;
    logic       obj_cap;
    logic       pix_rd;
    logic       pix_wr;
    logic       bit_next;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       visible;
    logic       bg_en;
    logic       obj_en;
    logic       x_last;
    logic       s_last;
    logic       hit;
    logic       b_last;
  } dp_sts_t;

  function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] idx);
    shade_of = pal[{idx, 1'b0} +: 2];
  endfunction

endpackage

// ===== rtl/tssr_ram.sv =====
// generic single write port, single read port memory with registered read
// no dependencies
module tssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tssr_ctrl.sv =====
// renderer controller: sequences clearing, item handling and line drawing
// depends on tssr_pkg; drives tssr_dp through dp_cmd_t / dp_sts_t
module tssr_ctrl
  import tssr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_DEC  = 5'd2;
  localparam logic [4:0] ST_RD   = 5'd3;
  localparam logic [4:0] ST_BMAP = 5'd4;
  localparam logic [4:0] ST_BLO  = 5'd5;
  localparam logic [4:0] ST_BHI  = 5'd6;
  localparam logic [4:0] ST_BWR  = 5'd7;
  localparam logic [4:0] ST_SY   = 5'd8;
  localparam logic [4:0] ST_SX   = 5'd9;
  localparam logic [4:0] ST_ST   = 5'd10;
  localparam logic [4:0] ST_SF   = 5'd11;
  localparam logic [4:0] ST_SCHK = 5'd12;
  localparam logic [4:0] ST_SLO  = 5'd13;
  localparam logic [4:0] ST_SHI  = 5'd14;
  localparam logic [4:0] ST_SCAP = 5'd15;
  localparam logic [4:0] ST_PRD  = 5'd16;
  localparam logic [4:0] ST_PWR  = 5'd17;
  localparam logic [4:0] ST_FIN  = 5'd18;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_FIN);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.accept = start;
        if (start) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.decode   = 1'b1;
        cmd.loop_clr = 1'b1;
        if (sts.op == OP_READ) begin
          state_nxt = ST_RD;
        end else if (sts.op == OP_DRAW && sts.visible) begin
          if (sts.bg_en) begin
            state_nxt = ST_BMAP;
          end else if (sts.obj_en) begin
            state_nxt = ST_SY;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_RD: begin
        cmd.cap_shade = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_BMAP: begin
        cmd.bg_map = 1'b1;
        state_nxt  = ST_BLO;
      end
      ST_BLO: begin
        cmd.bg_lo = 1'b1;
        state_nxt = ST_BHI;
      end
      ST_BHI: begin
        cmd.bg_hi = 1'b1;
        state_nxt = ST_BWR;
      end
      ST_BWR: begin
        cmd.bg_wr = 1'b1;
        if (!sts.x_last) begin
          state_nxt = ST_BMAP;
        end else if (sts.obj_en) begin
          state_nxt = ST_SY;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SY: begin
        cmd.oam_k = 2'd0;
        state_nxt = ST_SX;
      end
      ST_SX: begin
        cmd.cap_y = 1'b1;
        cmd.oam_k = 2'd1;
        state_nxt = ST_ST;
      end
      ST_ST: begin
        cmd.cap_x = 1'b1;
        cmd.oam_k = 2'd2;
        state_nxt = ST_SF;
      end
      ST_SF: begin
        cmd.cap_t = 1'b1;
        cmd.oam_k = 2'd3;
        state_nxt = ST_SCHK;
      end
      ST_SCHK: begin
        cmd.cap_f = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_SLO;
        end else if (sts.s_last) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.obj_next = 1'b1;
          state_nxt    = ST_SY;
        end
      end
      ST_SLO: begin
        cmd.obj_lo = 1'b1;
        state_nxt  = ST_SHI;
      end
      ST_SHI: begin
        cmd.obj_hi = 1'b1;
        state_nxt  = ST_SCAP;
      end
      ST_SCAP: begin
        cmd.obj_cap = 1'b1;
        state_nxt   = ST_PRD;
      end
      ST_PRD: begin
        cmd.pix_rd = 1'b1;
        state_nxt  = ST_PWR;
      end
      ST_PWR: begin
        cmd.pix_wr   = 1'b1;
        cmd.bit_next = 1'b1;
        if (!sts.b_last) begin
          state_nxt = ST_PRD;
        end else if (sts.s_last) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.obj_next = 1'b1;
          state_nxt    = ST_SY;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tssr_dp.sv =====
// renderer datapath: registers, memories, counters and pixel arithmetic
// depends on tssr_pkg and tssr_ram; commanded by tssr_ctrl
module tssr_dp
  import tssr_pkg::*;
#(
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
  parameter int OBJECT_COUNT   = OBJECT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [1:0]  in_op,
  input  logic [12:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_line,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic [1:0]  out_pixel_shade,
  output logic [1:0]  out_mode,
  output logic        out_coincidence,
  output logic        out_vblank_interrupt,
  output logic        out_status_interrupt,
  output logic [7:0]  out_current_line
);

  localparam int COL_W    = $clog2(SCREEN_COLUMNS);
  localparam int FB_DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int FB_AW    = $clog2(FB_DEPTH);
  localparam int NOBJ     = (OBJECT_COUNT < TABLE_OBJECTS) ? OBJECT_COUNT : TABLE_OBJECTS;
  localparam int OBJ_W    = (NOBJ > 1) ? $clog2(NOBJ) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [OBJ_W-1:0] OBJ_LAST = OBJ_W'(NOBJ - 1);
  localparam logic [FB_AW-1:0] FB_LAST  = FB_AW'(FB_DEPTH - 1);
  localparam logic [8:0]  COLS9  = 9'(SCREEN_COLUMNS);
  localparam logic [8:0]  ROWS9  = 9'(SCREEN_ROWS);
  localparam logic [9:0]  COLS10 = 10'(SCREEN_COLUMNS);
  localparam logic [16:0] COLS17 = 17'(SCREEN_COLUMNS);
  localparam logic [12:0] OAM_END = 13'(TABLE_BYTES);

  // configuration
  logic [7:0]  lcdc_r, bgp_r, lyc_r;
  logic [15:0] scrl_r, win_r, obp_r;
  logic [1:0]  sten_r;

  // latched request
  logic [1:0]       op_r;
  logic [12:0]      addr_r;
  logic [7:0]       data_r, ln_r, px_r, py_r;
  logic [FB_AW-1:0] row_base_r;

  // visible state
  logic [7:0] line_reg_r, line_reg_nxt;
  logic [1:0] mode_r, mode_nxt, shade_r;
  logic       coin_r, coin_nxt, vbl_r, vbl_nxt, stat_r, stat_nxt;

  // sequencing
  logic [FB_AW-1:0] clr_r;
  logic [COL_W-1:0] x_r;
  logic [OBJ_W-1:0] s_r;
  logic [2:0]       b_r;
  logic [12:0]      trow_r;
  logic [7:0]       lo_r, hi_r, ey_r, ex_r, et_r, ef_r;

  logic [7:0]       vram_rd, oam_rd;
  logic [1:0]       fb_rd;
  logic [12:0]      vram_raddr;
  logic [FB_AW-1:0] fb_waddr, fb_raddr, pix_addr;
  logic [1:0]       fb_wdata;
  logic             fb_we, vram_we, oam_we;

  logic [7:0]  rb_src;
  logic [16:0] rb_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcdc_r <= '0;
      scrl_r <= '0;
      win_r  <= '0;
      bgp_r  <= '0;
      obp_r  <= '0;
      lyc_r  <= '0;
      sten_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LCDC: lcdc_r <= cfg_data[7:0];
        CFG_SCRL: scrl_r <= cfg_data;
        CFG_WIN:  win_r  <= cfg_data;
        CFG_BGP:  bgp_r  <= cfg_data[7:0];
        CFG_OBP:  obp_r  <= cfg_data;
        CFG_LYC:  lyc_r  <= cfg_data[7:0];
        CFG_STEN: sten_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // row base serves both drawing (line) and pixel readback (pixel_y)
  assign rb_src  = (in_op == OP_READ) ? in_pixel_y : in_line;
  assign rb_prod = {9'b0, rb_src} * COLS17;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_op;
      addr_r     <= in_address;
      data_r     <= in_data;
      ln_r       <= in_line;
      px_r       <= in_pixel_x;
      py_r       <= in_pixel_y;
      row_base_r <= FB_AW'(rb_prod);
    end
  end

  always_comb begin
    line_reg_nxt = line_reg_r;
    mode_nxt     = mode_r;
    vbl_nxt      = vbl_r;
    stat_nxt     = stat_r;
    coin_nxt     = coin_r;
    if (cmd.decode && op_r == OP_DRAW) begin
      line_reg_nxt = ln_r;
      if ({1'b0, ln_r} == ROWS9) begin
        mode_nxt = 2'd1;
        vbl_nxt  = 1'b1;
        if (sten_r[0]) begin
          stat_nxt = 1'b1;
        end
      end else if ({1'b0, ln_r} < ROWS9) begin
        mode_nxt = 2'd0;
        vbl_nxt  = 1'b0;
      end
      if (ln_r == lyc_r) begin
        coin_nxt = 1'b1;
        if (sten_r[1]) begin
          stat_nxt = 1'b1;
        end
      end else begin
        coin_nxt = 1'b0;
        stat_nxt = 1'b0;
      end
    end
  end

  // background and window fetch
  logic [7:0]  bg_x, bg_y, wy, pix_x, pix_y;
  logic [9:0]  wx10;
  logic        use_win;
  logic [12:0] map_addr, tile_base, bg_row_addr;
  logic [2:0]  bg_sel;
  logic [1:0]  bg_shade;

  assign bg_x    = 8'(x_r) + scrl_r[7:0];
  assign bg_y    = ln_r + scrl_r[15:8];
  assign wx10    = 10'(x_r) + 10'd7 - {2'b0, win_r[7:0]};
  assign wy      = ln_r - win_r[15:8];
  assign use_win = lcdc_r[LCDC_WIN_EN] && (ln_r >= win_r[15:8]) && !wx10[9]
                   && (wx10 < COLS10);
  assign pix_x   = use_win ? wx10[7:0] : bg_x;
  assign pix_y   = use_win ? wy : bg_y;
  assign map_addr = ((use_win ? lcdc_r[LCDC_WIN_MAP] : lcdc_r[LCDC_BG_MAP]) ? MAP1_BASE
                     : MAP0_BASE) + 13'({pix_y[7:3], pix_x[7:3]});
  // signed tile numbers index around the middle of tile data
  assign tile_base = lcdc_r[LCDC_UNSIGN] ? {1'b0, vram_rd, 4'b0}
                     : SIGNED_BASE + {vram_rd[7], vram_rd, 4'b0};
  assign bg_row_addr = tile_base + 13'({pix_y[2:0], 1'b0});
  assign bg_sel      = 3'd7 - pix_x[2:0];
  assign bg_shade    = shade_of(bgp_r, {vram_rd[bg_sel], lo_r[bg_sel]});

  // sprite fetch
  logic        h16, hit, px_ok, spr_we;
  logic [9:0]  dy10, pxs;
  logic [3:0]  r4, rr;
  logic [7:0]  tnum, spr_pal;
  logic [12:0] spr_addr;
  logic [2:0]  col, spr_sel;
  logic [1:0]  spr_idx;

  assign h16  = lcdc_r[LCDC_OBJ_16];
  assign dy10 = 10'(ln_r) + 10'd16 - 10'(ey_r);
  assign hit  = !dy10[9] && (dy10 < (h16 ? 10'd16 : 10'd8));
  assign r4   = dy10[3:0];
  assign rr   = ef_r[6] ? (h16 ? ~r4 : {1'b0, ~r4[2:0]}) : r4;
  assign tnum = h16 ? {et_r[7:1], 1'b0} : et_r;
  assign spr_addr = {1'b0, tnum, 4'b0} + 13'({rr, 1'b0});
  assign col     = ef_r[5] ? 3'd7 - b_r : b_r;
  assign spr_sel = 3'd7 - col;
  assign spr_idx = {hi_r[spr_sel], lo_r[spr_sel]};
  assign pxs     = 10'(ex_r) + 10'(b_r) - 10'd8;
  assign px_ok   = !pxs[9] && (pxs < COLS10);
  assign pix_addr = row_base_r + FB_AW'(pxs[7:0]);
  assign spr_pal  = ef_r[4] ? obp_r[15:8] : obp_r[7:0];
  // behind-background sprites only cover shade zero
  assign spr_we   = cmd.pix_wr && (spr_idx != 2'd0) && px_ok && !(ef_r[7] && fb_rd != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_reg_r <= '0;
      mode_r     <= '0;
      coin_r     <= 1'b0;
      vbl_r      <= 1'b0;
      stat_r     <= 1'b0;
      clr_r      <= '0;
      x_r        <= '0;
      s_r        <= '0;
      b_r        <= '0;
    end else begin
      line_reg_r <= line_reg_nxt;
      mode_r     <= mode_nxt;
      coin_r     <= coin_nxt;
      vbl_r      <= vbl_nxt;
      stat_r     <= stat_nxt;
      if (cmd.clr) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.loop_clr) begin
        x_r <= '0;
        s_r <= '0;
      end else begin
        if (cmd.bg_wr) begin
          x_r <= x_r + 1'b1;
        end
        if (cmd.obj_next) begin
          s_r <= s_r + 1'b1;
        end
      end
      if (cmd.obj_cap) begin
        b_r <= '0;
      end else if (cmd.bit_next) begin
        b_r <= b_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      shade_r <= 2'd0;
    end else if (cmd.cap_shade) begin
      shade_r <= (({1'b0, px_r} < COLS9) && ({1'b0, py_r} < ROWS9)) ? fb_rd : 2'd0;
    end
    if (cmd.bg_lo) begin
      trow_r <= bg_row_addr;
    end
    if (cmd.bg_hi || cmd.obj_hi) begin
      lo_r <= vram_rd;
    end
    if (cmd.obj_cap) begin
      hi_r <= vram_rd;
    end
    if (cmd.cap_y) begin
      ey_r <= oam_rd;
    end
    if (cmd.cap_x) begin
      ex_r <= oam_rd;
    end
    if (cmd.cap_t) begin
      et_r <= oam_rd;
    end
    if (cmd.cap_f) begin
      ef_r <= oam_rd;
    end
  end

  always_comb begin
    if (cmd.bg_map) begin
      vram_raddr = map_addr;
    end else if (cmd.bg_lo) begin
      vram_raddr = bg_row_addr;
    end else if (cmd.bg_hi) begin
      vram_raddr = trow_r + 13'd1;
    end else if (cmd.obj_lo) begin
      vram_raddr = spr_addr;
    end else begin
      vram_raddr = spr_addr + 13'd1;
    end
  end

  assign vram_we = cmd.decode && (op_r == OP_VRAM);
  assign oam_we  = cmd.decode && (op_r == OP_OAM) && (addr_r < OAM_END);

  assign fb_we    = cmd.clr || cmd.bg_wr || spr_we;
  assign fb_waddr = cmd.clr ? clr_r : (cmd.bg_wr ? row_base_r + FB_AW'(x_r) : pix_addr);
  assign fb_wdata = cmd.clr ? 2'd0 : (cmd.bg_wr ? bg_shade : shade_of(spr_pal, spr_idx));
  assign fb_raddr = cmd.pix_rd ? pix_addr : row_base_r + FB_AW'(px_r);

  tssr_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (addr_r),
    .wdata (data_r),
    .raddr (vram_raddr),
    .rdata (vram_rd)
  );

  tssr_ram #(.WIDTH(8), .DEPTH(TABLE_BYTES)) u_oam (
    .clk   (clk),
    .we    (oam_we),
    .waddr (addr_r[OAM_AW-1:0]),
    .wdata (data_r),
    .raddr (OAM_AW'({s_r, cmd.oam_k})),
    .rdata (oam_rd)
  );

  tssr_ram #(.WIDTH(2), .DEPTH(FB_DEPTH)) u_fb (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_rd)
  );

  assign sts.clr_last = (clr_r == FB_LAST);
  assign sts.op       = op_r;
  assign sts.visible  = ({1'b0, ln_r} < ROWS9);
  assign sts.bg_en    = lcdc_r[LCDC_BG_EN];
  assign sts.obj_en   = lcdc_r[LCDC_OBJ_EN];
  assign sts.x_last   = (x_r == COL_LAST);
  assign sts.s_last   = (s_r == OBJ_LAST);
  assign sts.hit      = hit;
  assign sts.b_last   = (b_r == 3'd7);

  assign out_pixel_shade      = shade_r;
  assign out_mode             = mode_r;
  assign out_coincidence      = coin_r;
  assign out_vblank_interrupt = vbl_r;
  assign out_status_interrupt = stat_r;
  assign out_current_line     = line_reg_r;

  a_bg_wr_after_hi: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bg_wr |-> $past(cmd.bg_hi))
    else $error("background write without preceding high byte fetch");
  a_pix_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_wr |-> $past(cmd.pix_rd))
    else $error("sprite pixel write without frame buffer read");
  a_shade_after_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_shade |-> $past(cmd.decode) && op_r == OP_READ)
    else $error("shade capture outside a pixel read");

endmodule

// ===== rtl/tile_sprite_scanline_renderer.sv =====
// tile and sprite scanline renderer, top level
// depends on tssr_pkg, tssr_ctrl, tssr_dp (which holds the tssr_ram memories)

// Requests are taken when start is high and busy low; each produces exactly one
// result, shown for one cycle with out_valid high, and the receiver cannot stall.
// After reset the frame buffer, SCREEN_COLUMNS*SCREEN_ROWS entries, is cleared
// with busy high. Memory writes and non-drawing lines go from decode straight to
// the result; pixel reads add a shade capture. A visible line reads, for each
// background and window pixel, one map and two tile bytes, all through the single
// video memory read port, and writes the pixel; when sprites are on it also scans
// every object entry and, for each object on the line, fetches two tile bytes and
// reads and writes the frame buffer for each of its 8 pixels.
module tile_sprite_scanline_renderer
  import tssr_pkg::*;
#(
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
  parameter int OBJECT_COUNT   = OBJECT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [12:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_line,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  output logic        out_valid,
  output logic [1:0]  out_pixel_shade,
  output logic [1:0]  out_mode,
  output logic        out_coincidence,
  output logic        out_vblank_interrupt,
  output logic        out_status_interrupt,
  output logic [7:0]  out_current_line,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tssr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tssr_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .OBJECT_COUNT   (OBJECT_COUNT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_op),
    .in_address           (in_address),
    .in_data              (in_data),
    .in_line              (in_line),
    .in_pixel_x           (in_pixel_x),
    .in_pixel_y           (in_pixel_y),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_pixel_shade      (out_pixel_shade),
    .out_mode             (out_mode),
    .out_coincidence      (out_coincidence),
    .out_vblank_interrupt (out_vblank_interrupt),
    .out_status_interrupt (out_status_interrupt),
    .out_current_line     (out_current_line)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("request accepted but block not busy");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");
  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

endmodule
